FILE: rtl/bres_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the Bresenham line pixel generator.
// No dependencies; used by every module under rtl/.

package bres_pkg;

    localparam int COORD_BITS_DEF = 16;

    // configuration register file
    localparam int CFG_BITS       = 13;
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 1'b1;
    localparam logic [CFG_BITS-1:0] SCREEN_WIDTH_RESET  = 13'd640;
    localparam logic [CFG_BITS-1:0] SCREEN_HEIGHT_RESET = 13'd480;

    // command codes carried in tuser
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    // per-item flags passed from the front stage to the walker
    typedef struct packed {
        logic cmd;
        logic x_neg;
        logic y_neg;
    } front_flags_t;

endpackage

FILE: rtl/bres_front.sv
`timescale 1ns / 1ps
// Input stage: registers an accepted item and works out the signed deltas.
// Depends on bres_pkg.

module bres_front #(
    parameter int COORD_BITS = bres_pkg::COORD_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       in_cmd,
    input  logic [COORD_BITS-1:0]      in_x0,
    input  logic [COORD_BITS-1:0]      in_y0,
    input  logic [COORD_BITS-1:0]      in_x1,
    input  logic [COORD_BITS-1:0]      in_y1,
    output logic                       out_valid,
    input  logic                       out_ready,
    output bres_pkg::front_flags_t     out_flags,
    output logic [COORD_BITS-1:0]      out_x0,
    output logic [COORD_BITS-1:0]      out_y0,
    output logic [COORD_BITS-1:0]      out_adx,
    output logic [COORD_BITS-1:0]      out_ady
);

    logic                    valid_reg, valid_next;
    bres_pkg::front_flags_t  flags_reg;
    logic [COORD_BITS-1:0]   x0_reg, y0_reg, adx_reg, ady_reg;

    logic                    in_fire;
    logic [COORD_BITS:0]     dx, dy, dx_abs, dy_abs;

    assign in_ready = !valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // one extra bit keeps the difference of two signed coordinates exact
    assign dx     = {in_x1[COORD_BITS-1], in_x1} - {in_x0[COORD_BITS-1], in_x0};
    assign dy     = {in_y1[COORD_BITS-1], in_y1} - {in_y0[COORD_BITS-1], in_y0};
    assign dx_abs = dx[COORD_BITS] ? (~dx + (COORD_BITS+1)'(1)) : dx;
    assign dy_abs = dy[COORD_BITS] ? (~dy + (COORD_BITS+1)'(1)) : dy;

    always_comb begin
        valid_next = valid_reg;
        if (in_fire) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            flags_reg.cmd   <= in_cmd;
            flags_reg.x_neg <= dx[COORD_BITS];
            flags_reg.y_neg <= dy[COORD_BITS];
            x0_reg          <= in_x0;
            y0_reg          <= in_y0;
            adx_reg         <= dx_abs[COORD_BITS-1:0];
            ady_reg         <= dy_abs[COORD_BITS-1:0];
        end
    end

    assign out_valid = valid_reg;
    assign out_flags = flags_reg;
    assign out_x0    = x0_reg;
    assign out_y0    = y0_reg;
    assign out_adx   = adx_reg;
    assign out_ady   = ady_reg;

endmodule

FILE: rtl/bres_walk.sv
`timescale 1ns / 1ps
// Line walker: holds the Bresenham state and screen size, steps one pixel
// per advance item and registers the result. Depends on bres_pkg.

module bres_walk #(
    parameter int COORD_BITS = bres_pkg::COORD_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [bres_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [bres_pkg::CFG_BITS-1:0]          cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  bres_pkg::front_flags_t                 in_flags,
    input  logic [COORD_BITS-1:0]                  in_x0,
    input  logic [COORD_BITS-1:0]                  in_y0,
    input  logic [COORD_BITS-1:0]                  in_adx,
    input  logic [COORD_BITS-1:0]                  in_ady,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [COORD_BITS-1:0]                  out_x,
    output logic [COORD_BITS-1:0]                  out_y,
    output logic                                   out_on_screen,
    output logic                                   out_last
);

    localparam int ERR_W = COORD_BITS + 3;
    localparam int CMP_W = (COORD_BITS > bres_pkg::CFG_BITS) ? COORD_BITS
                                                              : bres_pkg::CFG_BITS;

    logic [bres_pkg::CFG_BITS-1:0] width_reg, width_next;
    logic [bres_pkg::CFG_BITS-1:0] height_reg, height_next;

    logic                    active_reg, active_next;
    logic [COORD_BITS:0]     left_reg, left_next;
    logic [COORD_BITS-1:0]   cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0]   cur_y_reg, cur_y_next;
    logic [ERR_W-1:0]        err_reg, err_next;
    logic [COORD_BITS:0]     tmaj_reg, tmaj_next;
    logic [COORD_BITS:0]     tmin_reg, tmin_next;
    logic                    x_neg_reg, x_neg_next;
    logic                    y_neg_reg, y_neg_next;
    logic                    x_major_reg, x_major_next;

    logic                    ovalid_reg, ovalid_next;
    logic [COORD_BITS-1:0]   ox_reg, oy_reg;
    logic                    oon_reg, olast_reg;

    logic                    is_load, take, produce, fin, err_ge, on_x, on_y, x_major;
    logic [COORD_BITS-1:0]   major, minor;

    assign is_load  = (in_flags.cmd == bres_pkg::CMD_LOAD);
    // loads and idle advances give nothing, so they never wait on the output
    assign in_ready = is_load || !active_reg || !ovalid_reg || out_ready;
    assign take     = in_valid && in_ready;
    assign produce  = take && !is_load && active_reg;
    assign fin      = (left_reg == (COORD_BITS+1)'(1));
    assign err_ge   = !err_reg[ERR_W-1];

    assign x_major  = in_adx > in_ady;
    assign major    = x_major ? in_adx : in_ady;
    assign minor    = x_major ? in_ady : in_adx;

    assign on_x = !cur_x_reg[COORD_BITS-1] && (CMP_W'(cur_x_reg) < CMP_W'(width_reg));
    assign on_y = !cur_y_reg[COORD_BITS-1] && (CMP_W'(cur_y_reg) < CMP_W'(height_reg));

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                bres_pkg::REG_SCREEN_WIDTH:  width_next  = cfg_data;
                bres_pkg::REG_SCREEN_HEIGHT: height_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        active_next  = active_reg;
        left_next    = left_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        err_next     = err_reg;
        tmaj_next    = tmaj_reg;
        tmin_next    = tmin_reg;
        x_neg_next   = x_neg_reg;
        y_neg_next   = y_neg_reg;
        x_major_next = x_major_reg;
        if (take && is_load) begin
            active_next  = 1'b1;
            left_next    = {1'b0, major} + (COORD_BITS+1)'(1);
            cur_x_next   = in_x0;
            cur_y_next   = in_y0;
            err_next     = ERR_W'({minor, 1'b0}) - ERR_W'(major);
            tmaj_next    = {major, 1'b0};
            tmin_next    = {minor, 1'b0};
            x_neg_next   = in_flags.x_neg;
            y_neg_next   = in_flags.y_neg;
            x_major_next = x_major;
        end else if (produce) begin
            left_next = left_reg - (COORD_BITS+1)'(1);
            if (fin) begin
                active_next = 1'b0;
            end else begin
                err_next = err_reg + ERR_W'(tmin_reg)
                         - (err_ge ? ERR_W'(tmaj_reg) : ERR_W'(0));
                // major axis always steps, minor axis steps on a non-negative error
                if (x_major_reg || err_ge) begin
                    cur_x_next = cur_x_reg + (x_neg_reg ? {COORD_BITS{1'b1}}
                                                        : COORD_BITS'(1));
                end
                if (!x_major_reg || err_ge) begin
                    cur_y_next = cur_y_reg + (y_neg_reg ? {COORD_BITS{1'b1}}
                                                        : COORD_BITS'(1));
                end
            end
        end
    end

    always_comb begin
        ovalid_next = ovalid_reg;
        if (produce) begin
            ovalid_next = 1'b1;
        end else if (out_ready) begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= bres_pkg::SCREEN_WIDTH_RESET;
            height_reg  <= bres_pkg::SCREEN_HEIGHT_RESET;
            active_reg  <= 1'b0;
            left_reg    <= '0;
            ovalid_reg  <= 1'b0;
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            err_reg     <= '0;
            tmaj_reg    <= '0;
            tmin_reg    <= '0;
            x_neg_reg   <= 1'b0;
            y_neg_reg   <= 1'b0;
            x_major_reg <= 1'b0;
        end else begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            active_reg  <= active_next;
            left_reg    <= left_next;
            ovalid_reg  <= ovalid_next;
            cur_x_reg   <= cur_x_next;
            cur_y_reg   <= cur_y_next;
            err_reg     <= err_next;
            tmaj_reg    <= tmaj_next;
            tmin_reg    <= tmin_next;
            x_neg_reg   <= x_neg_next;
            y_neg_reg   <= y_neg_next;
            x_major_reg <= x_major_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (produce) begin
            ox_reg    <= cur_x_reg;
            oy_reg    <= cur_y_reg;
            oon_reg   <= on_x && on_y;
            olast_reg <= fin;
        end
    end

    assign out_valid     = ovalid_reg;
    assign out_x         = ox_reg;
    assign out_y         = oy_reg;
    assign out_on_screen = oon_reg;
    assign out_last      = olast_reg;

    a_active_has_pixels: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (left_reg != '0))
        else $error("active line with no pixels left");

    a_load_starts_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && is_load) |=> (active_reg && ($past(in_x0) == cur_x_reg)))
        else $error("load did not start a line at its first endpoint");

    a_last_ends_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (produce && fin) |=> (!active_reg && ovalid_reg && olast_reg))
        else $error("final pixel did not close the line");

    a_idle_advance_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && !is_load && !active_reg) |=> ($stable(cur_x_reg) && $stable(cur_y_reg)
                                               && !active_reg))
        else $error("advance without a line changed the state");

    a_result_not_lost: assert property (@(posedge aclk) disable iff (!aresetn)
        (ovalid_reg && !out_ready) |-> !produce)
        else $error("new pixel would overwrite an untaken result");

endmodule

FILE: rtl/bresenham_line_pixel_generator_unit.sv
`timescale 1ns / 1ps
// Bresenham line pixel generator: top level wiring the input stage and the
// walker. Depends on bres_pkg, bres_front and bres_walk.
//
// Usage:
//   Input channel (s_*): tuser is the command. A load item (tuser = 0) takes
//   start and end points in tdata and gives no result; it replaces any line
//   in progress. An advance item (tuser = 1) gives one pixel of the current
//   line, first endpoint to second inclusive; with no line active it gives
//   nothing.
//   Result channel (m_*): tdata holds the pixel, tuser the on-screen flag
//   (0 <= x < screen_width and 0 <= y < screen_height), tlast marks the
//   final pixel of the line.
//   Config port: write cfg_data to register cfg_index (0 width, 1 height)
//   while the block is idle; no read-back.
//   Path: an accepted advance item is registered in the input stage and
//   its pixel in the walker. Throughput: one item per cycle while no held
//   result stalls it; the walker does one add-and-compare per error step.
//   Stalls: a held result blocks only further advances that would produce
//   pixels; the input stage register absorbs one more item.
//   Reset: synchronous, aresetn low clears all valid flags and the active
//   line and restores the screen size to 640 x 480.

module bresenham_line_pixel_generator_unit #(
    parameter int COORD_BITS = bres_pkg::COORD_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [bres_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [bres_pkg::CFG_BITS-1:0]        cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // fields from bit 0: start_x, start_y, end_x, end_y, zero pad
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]    s_tdata,
    // fields from bit 0: cmd
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // fields from bit 0: pixel_x, pixel_y, zero pad
    output logic [((2*COORD_BITS+7)/8)*8-1:0]    m_tdata,
    // fields from bit 0: on_screen
    output logic                                 m_tuser,
    output logic                                 m_tlast
);

    localparam int M_TDATA_W = ((2*COORD_BITS+7)/8)*8;

    logic                    f_valid, f_ready;
    bres_pkg::front_flags_t  f_flags;
    logic [COORD_BITS-1:0]   f_x0, f_y0, f_adx, f_ady;
    logic [COORD_BITS-1:0]   px, py;

    bres_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser),
        .in_x0     (s_tdata[COORD_BITS-1:0]),
        .in_y0     (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .in_x1     (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .in_y1     (s_tdata[4*COORD_BITS-1:3*COORD_BITS]),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_flags (f_flags),
        .out_x0    (f_x0),
        .out_y0    (f_y0),
        .out_adx   (f_adx),
        .out_ady   (f_ady)
    );

    bres_walk #(
        .COORD_BITS (COORD_BITS)
    ) u_walk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (f_valid),
        .in_ready      (f_ready),
        .in_flags      (f_flags),
        .in_x0         (f_x0),
        .in_y0         (f_y0),
        .in_adx        (f_adx),
        .in_ady        (f_ady),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_x         (px),
        .out_y         (py),
        .out_on_screen (m_tuser),
        .out_last      (m_tlast)
    );

    assign m_tdata = M_TDATA_W'({py, px});

endmodule
